// ===== rtl/core/kpc_pkg.sv =====
// Package for the key press classifier.
// Holds the event codes, request opcodes, register indexes and shared types.
// It has no dependencies.
`default_nettype none

package kpc_pkg;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam int unsigned EVENT_W     = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_TICKS = 8'd0,
      CSR_PRESS_LIMIT  = 8'd1
   } csr_index_type;

   typedef enum logic {
      OP_SCAN = 1'b0,
      OP_READ = 1'b1
   } op_type;

   localparam logic [EVENT_W-1:0] EV_NONE   = 3'b000;
   localparam logic [EVENT_W-1:0] EV_DOUBLE = 3'b001;
   localparam logic [EVENT_W-1:0] EV_LONG   = 3'b010;
   localparam logic [EVENT_W-1:0] EV_SHORT  = 3'b100;

   localparam logic [CSR_DATA_W-1:0] WINDOW_TICKS_RESET = 8'd20;
   localparam logic [CSR_DATA_W-1:0] PRESS_LIMIT_RESET  = 8'd16;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] window_ticks;
      logic [CSR_DATA_W-1:0] press_limit;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/kpc_csr.sv =====
// Configuration registers of the key press classifier.
// Depends on kpc_pkg for register indexes, reset values and the cfg_type struct.
`default_nettype none

module kpc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr,
   input  wire logic [kpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [kpc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output      kpc_pkg::cfg_type                 cfg
);

   kpc_pkg::cfg_type cfg_ff;
   kpc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_index)
            kpc_pkg::CSR_WINDOW_TICKS: cfg_in.window_ticks = csr_wdata;
            kpc_pkg::CSR_PRESS_LIMIT:  cfg_in.press_limit  = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ticks <= kpc_pkg::WINDOW_TICKS_RESET;
         cfg_ff.press_limit  <= kpc_pkg::PRESS_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/kpc_core.sv =====
// Classification state and its next-state logic for the key press classifier.
// Depends on kpc_pkg for event codes, opcodes and the cfg_type struct.
`default_nettype none

module kpc_core #(
   parameter int unsigned COUNT_BITS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step_en,
   input  wire logic                         op,
   input  wire logic                         pin_level,
   input  wire kpc_pkg::cfg_type             cfg,
   output      logic [kpc_pkg::EVENT_W-1:0]  event_code
);

   localparam int unsigned CMP_W = (COUNT_BITS > kpc_pkg::CSR_DATA_W) ?
                                   COUNT_BITS : kpc_pkg::CSR_DATA_W;

   logic                        level_now_ff, level_now_in;
   logic                        level_before_ff, level_before_in;
   logic                        in_window_ff, in_window_in;
   logic                        short_seen_ff, short_seen_in;
   logic [kpc_pkg::EVENT_W-1:0] pending_ff, pending_in;
   logic [COUNT_BITS-1:0]       tick_count_ff, tick_count_in;
   logic [COUNT_BITS-1:0]       first_rel_ff, first_rel_in;

   logic                  fall;
   logic                  rise;
   logic [COUNT_BITS-1:0] gap;
   logic [CMP_W-1:0]      press_limit_x;
   logic [CMP_W-1:0]      window_x;

   always_comb begin
      level_now_in    = level_now_ff;
      level_before_in = level_before_ff;
      in_window_in    = in_window_ff;
      short_seen_in   = short_seen_ff;
      pending_in      = pending_ff;
      tick_count_in   = tick_count_ff;
      first_rel_in    = first_rel_ff;
      fall            = 1'b0;
      rise            = 1'b0;
      gap             = '0;
      press_limit_x   = CMP_W'(cfg.press_limit);
      window_x        = CMP_W'(cfg.window_ticks);
      event_code      = kpc_pkg::EV_NONE;

      if (op == kpc_pkg::OP_READ) begin
         event_code = pending_ff;
         pending_in = kpc_pkg::EV_NONE;
      end else begin
         if (in_window_ff) begin
            tick_count_in = COUNT_BITS'(tick_count_ff + 1'b1);
         end
         level_before_in = level_now_ff;
         level_now_in    = pin_level;
         fall = level_now_ff & ~pin_level;
         rise = ~level_now_ff & pin_level;
         gap  = COUNT_BITS'(tick_count_in - first_rel_ff);

         if (fall) begin
            if (!in_window_ff) begin
               in_window_in  = 1'b1;
               tick_count_in = '0;
               first_rel_in  = '0;
            end
         end else if (rise) begin
            if (!in_window_ff) begin
               pending_in    = kpc_pkg::EV_LONG;
               in_window_in  = 1'b0;
               short_seen_in = 1'b0;
               tick_count_in = '0;
               first_rel_in  = '0;
            end else if (!short_seen_ff) begin
               if (CMP_W'(tick_count_in) >= press_limit_x) begin
                  pending_in    = kpc_pkg::EV_LONG;
                  in_window_in  = 1'b0;
                  short_seen_in = 1'b0;
                  tick_count_in = '0;
                  first_rel_in  = '0;
               end else begin
                  short_seen_in = 1'b1;
                  first_rel_in  = tick_count_in;
               end
            end else if (CMP_W'(gap) <= press_limit_x) begin
               pending_in    = kpc_pkg::EV_DOUBLE;
               in_window_in  = 1'b0;
               short_seen_in = 1'b0;
               tick_count_in = '0;
               first_rel_in  = '0;
            end
         end

         if (CMP_W'(tick_count_in) >= window_x) begin
            if (short_seen_in &&
                ((pending_in & (kpc_pkg::EV_DOUBLE | kpc_pkg::EV_LONG)) ==
                 kpc_pkg::EV_NONE)) begin
               pending_in = pending_in | kpc_pkg::EV_SHORT;
            end
            in_window_in  = 1'b0;
            short_seen_in = 1'b0;
            tick_count_in = '0;
            first_rel_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_now_ff    <= 1'b1;
         level_before_ff <= 1'b1;
         in_window_ff    <= 1'b0;
         short_seen_ff   <= 1'b0;
         pending_ff      <= kpc_pkg::EV_NONE;
         tick_count_ff   <= '0;
         first_rel_ff    <= '0;
      end else if (step_en) begin
         level_now_ff    <= level_now_in;
         level_before_ff <= level_before_in;
         in_window_ff    <= in_window_in;
         short_seen_ff   <= short_seen_in;
         pending_ff      <= pending_in;
         tick_count_ff   <= tick_count_in;
         first_rel_ff    <= first_rel_in;
      end
   end

   // The counter only runs while a window is open.
   assert property (@(posedge clock) disable iff (reset)
      !in_window_ff |-> (tick_count_ff == '0))
      else $error("tick counter nonzero outside a window");

   assert property (@(posedge clock) disable iff (reset)
      short_seen_ff |-> in_window_ff)
      else $error("short press recorded outside a window");

   // Events are mutually exclusive.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(pending_ff))
      else $error("more than one pending event");

   assert property (@(posedge clock) disable iff (reset)
      (step_en && op == kpc_pkg::OP_READ) |=> (pending_ff == kpc_pkg::EV_NONE))
      else $error("pending events not cleared by a read");

endmodule

`default_nettype wire

// ===== rtl/core/key_press_classifier.sv =====
// Key press classifier for an active-low push button fed with scan samples.
//
// Request channel (req_valid/req_ready): req_op selects a scan tick
// (req_pin_level is the sampled pin, 1 released, 0 pressed) or a read
// that returns and clears the pending events. Every request gives exactly
// one response on rsp_valid/rsp_ready; rsp_event_code is zero for a scan
// tick and the pending events (bit0 double, bit1 long, bit2 short) for a read.
// The configuration channel (csr_valid/csr_ready) writes window_ticks at
// index 0 and press_limit at index 1; other indexes are ignored. It is
// always ready and should only be written while no request is in flight.
// An accepted request is held in the input register, then moves into the
// response register when that register is empty or being read. The state
// update for a request happens as it leaves the input register, so one
// request per cycle is sustained while the receiver keeps rsp_ready high.
// When the receiver stalls, the response register holds and the input
// register still takes one more request.
// Reset is synchronous and returns the state, configuration and valid flags to defaults.
// Depends on kpc_pkg, kpc_csr and kpc_core.
`default_nettype none

module key_press_classifier #(
   parameter int unsigned COUNT_BITS = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic                            req_op,
   input  wire logic                            req_pin_level,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [kpc_pkg::EVENT_W-1:0]     rsp_event_code,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [kpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [kpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                        s1_valid_ff;
   logic                        s1_op_ff;
   logic                        s1_pin_ff;
   logic                        rsp_valid_ff;
   logic [kpc_pkg::EVENT_W-1:0] rsp_code_ff;
   logic [kpc_pkg::EVENT_W-1:0] event_code;
   logic                        advance;
   kpc_pkg::cfg_type            cfg;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;

   kpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kpc_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .op         (s1_op_ff),
      .pin_level  (s1_pin_ff),
      .cfg        (cfg),
      .event_code (event_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff  <= req_op;
         s1_pin_ff <= req_pin_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_code_ff <= event_code;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_code_ff;

endmodule

`default_nettype wire
